>>> hdl/stiffened_gas_eos_eval_unit_assert.svh
// Assertion macros for the stiffened-gas EOS evaluator RTL.
`ifndef STIFFENED_GAS_EOS_EVAL_UNIT_ASSERT_SVH
`define STIFFENED_GAS_EOS_EVAL_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SGEE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgee assertion failed");
// next-cycle implication
`define SGEE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgee assertion failed");
`else
`define SGEE_ASSERT_IMP(label, clk, rst, ante, cons)
`define SGEE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hdl/sgee_pkg.sv
// Types and constants for the stiffened-gas EOS evaluator.
`timescale 1ns / 1ps
`default_nettype none
package sgee_pkg;

  localparam int DataW  = 32;          // Q16.16 word
  localparam int FracW  = 16;
  localparam int GammaW = 20;          // unsigned Q4.16
  localparam int ProdW  = 53;          // exact products and numerators
  localparam int EDivW  = 53;          // energy divisor magnitude
  localparam int EQuoW  = 2 * FracW;   // energy quotient bits
  localparam int SDivW  = 32;          // density magnitude
  localparam int SQuoW  = 62;          // radicand bits
  localparam int RootW  = 31;          // sound speed bits

  localparam logic [GammaW-1:0] GammaReset = 20'd91750;
  localparam logic [GammaW:0]   OneFx      = 21'd65536;

  typedef enum logic [1:0] {
    CFG_GAMMA          = 2'd0,
    CFG_STIFF_PRESSURE = 2'd1,
    CFG_ENERGY_OFFSET  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SPEED_OK           = 2'd0,
    SPEED_DENSITY_ZERO = 2'd1,
    SPEED_RADICAND     = 2'd2
  } speed_err_t;

  typedef struct packed {
    logic signed [DataW-1:0] pressure;
    logic signed [DataW-1:0] density;
  } sample_t;

  typedef struct packed {
    logic signed [DataW-1:0] energy;
    logic [RootW-1:0]        sound_speed;
    logic                    energy_error;
    speed_err_t              speed_error;
  } result_t;

  // front end to divider pipelines
  typedef struct packed {
    logic             neg;
    logic             eerr;
    logic             esat;
    logic [ProdW-1:0] mag_ne;
    logic [EDivW-1:0] mag_de;
    speed_err_t       serr;
    logic             ssat;
    logic [ProdW-1:0] mag_ns;
    logic [SDivW-1:0] mag_rho;
  } front_t;

  // carried alongside the energy division
  typedef struct packed {
    logic             neg;
    logic             eerr;
    logic             esat;
    speed_err_t       serr;
    logic             ssat;
    logic [ProdW-1:0] mag_ns;
    logic [SDivW-1:0] mag_rho;
  } eside_t;

  // carried alongside the speed division
  typedef struct packed {
    logic signed [DataW-1:0] energy;
    logic                    eerr;
    speed_err_t              serr;
    logic                    ssat;
  } sside_t;

  // carried alongside the square root
  typedef struct packed {
    logic signed [DataW-1:0] energy;
    logic                    eerr;
    speed_err_t              serr;
  } rside_t;

endpackage
`default_nettype wire

>>> hdl/sgee_front.sv
// Front end: products, numerators, magnitudes, error and saturation flags.
`timescale 1ns / 1ps
`default_nettype none
module sgee_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               in_valid,
  input  sgee_pkg::sample_t                  sample,
  input  logic [sgee_pkg::GammaW-1:0]        gamma,
  input  logic signed [sgee_pkg::DataW-1:0]  stiff_pressure,
  output logic                               out_valid,
  output sgee_pkg::front_t                   front
);

  localparam int PW    = sgee_pkg::ProdW;
  localparam int DW    = sgee_pkg::DataW;
  localparam int FW    = sgee_pkg::FracW;
  localparam int GW    = sgee_pkg::GammaW;
  localparam int SW    = sgee_pkg::SDivW;
  localparam int PPW   = DW + 1;
  localparam int SatSh = sgee_pkg::SQuoW - sgee_pkg::FracW;
  localparam int CmpW  = SW + SatSh;
  localparam int ECmpW = PW + FW;

  logic                 v1, v2;
  logic signed [DW-1:0] p1, rho1, rho2;
  logic signed [PW-1:0] gp1, den1, num_e2, num_s2, den2;
  logic signed [PPW-1:0] pp1;
  logic signed [GW:0]   gm1;
  logic signed [PW-1:0] g_x, pinf_x, gm1_x, rho_x, p_x, pp_x;
  logic [PW-1:0]        mag_ne, mag_de, mag_ns;
  logic [SW-1:0]        mag_rho;
  sgee_pkg::front_t     front_next;

  assign gm1    = $signed({1'b0, gamma} - sgee_pkg::OneFx);
  assign g_x    = PW'($signed({1'b0, gamma}));
  assign pinf_x = PW'(stiff_pressure);
  assign gm1_x  = PW'(gm1);
  assign rho_x  = PW'(sample.density);
  assign p_x    = PW'(p1);
  assign pp_x   = PW'(pp1);

  // stage 1: g*pinf, (g-1)*rho, p+pinf
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1   <= sample.pressure;
      rho1 <= sample.density;
      gp1  <= g_x * pinf_x;
      den1 <= gm1_x * rho_x;
      pp1  <= PPW'(sample.pressure) + PPW'(stiff_pressure);
    end
  end

  // stage 2: energy numerator, speed numerator g*(p+pinf)
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_e2 <= (p_x <<< FW) + gp1;
      num_s2 <= g_x * pp_x;
      den2   <= den1;
      rho2   <= rho1;
    end
  end

  // stage 3: magnitudes, flags
  assign mag_ne  = num_e2[PW-1] ? $unsigned(-num_e2) : $unsigned(num_e2);
  assign mag_de  = den2[PW-1]   ? $unsigned(-den2)   : $unsigned(den2);
  assign mag_ns  = num_s2[PW-1] ? $unsigned(-num_s2) : $unsigned(num_s2);
  assign mag_rho = rho2[DW-1]   ? $unsigned(-rho2)   : $unsigned(rho2);

  always_comb begin
    front_next.neg     = num_e2[PW-1] ^ den2[PW-1];
    front_next.eerr    = (den2 == '0);
    front_next.esat    = (ECmpW'(mag_ne) >= {mag_de, {FW{1'b0}}});
    front_next.mag_ne  = mag_ne;
    front_next.mag_de  = mag_de;
    front_next.serr    = sgee_pkg::SPEED_OK;
    front_next.ssat    = (CmpW'(mag_ns) >= {mag_rho, {SatSh{1'b0}}});
    front_next.mag_ns  = mag_ns;
    front_next.mag_rho = mag_rho;
    if (rho2 == '0) begin
      front_next.serr = sgee_pkg::SPEED_DENSITY_ZERO;
    end else if (num_s2 == '0 || (num_s2[PW-1] != rho2[DW-1])) begin
      front_next.serr = sgee_pkg::SPEED_RADICAND;
    end
    // error: feed a zero radicand through the divider
    if (front_next.serr != sgee_pkg::SPEED_OK) begin
      front_next.ssat    = 1'b0;
      front_next.mag_ns  = '0;
      front_next.mag_rho = SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      front <= front_next;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sgee_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
`timescale 1ns / 1ps
`default_nettype none
module sgee_div_pipe #(
  parameter int DIV_W  = 32,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [DIV_W-1:0]  rem_init,
  input  logic [QUO_W-1:0]  low_bits,
  input  logic [SIDE_W-1:0] side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  quotient,
  output logic [SIDE_W-1:0] out_side
);

  // stage registers; word shifts dividend bits out the top, quotient bits in
  logic              st_valid [QUO_W];
  logic [DIV_W-1:0]  st_rem   [QUO_W];
  logic [DIV_W-1:0]  st_div   [QUO_W];
  logic [QUO_W-1:0]  st_word  [QUO_W];
  logic [SIDE_W-1:0] st_side  [QUO_W];

  logic              in_v [QUO_W];
  logic [DIV_W-1:0]  in_r [QUO_W];
  logic [DIV_W-1:0]  in_d [QUO_W];
  logic [QUO_W-1:0]  in_w [QUO_W];
  logic [SIDE_W-1:0] in_s [QUO_W];
  logic [DIV_W:0]    trial [QUO_W];
  logic [DIV_W:0]    diff  [QUO_W];
  logic [DIV_W-1:0]  rem_next  [QUO_W];
  logic [QUO_W-1:0]  word_next [QUO_W];

  // stage inputs
  always_comb begin
    in_v[0] = in_valid;
    in_r[0] = rem_init;
    in_d[0] = divisor;
    in_w[0] = low_bits;
    in_s[0] = side;
    for (int k = 1; k < QUO_W; k++) begin
      in_v[k] = st_valid[k-1];
      in_r[k] = st_rem[k-1];
      in_d[k] = st_div[k-1];
      in_w[k] = st_word[k-1];
      in_s[k] = st_side[k-1];
    end
  end

  // trial subtract per stage; remainder stays below the divisor
  always_comb begin
    for (int k = 0; k < QUO_W; k++) begin
      trial[k]     = {in_r[k], in_w[k][QUO_W-1]};
      diff[k]      = trial[k] - {1'b0, in_d[k]};
      rem_next[k]  = diff[k][DIV_W] ? trial[k][DIV_W-1:0] : diff[k][DIV_W-1:0];
      word_next[k] = {in_w[k][QUO_W-2:0], ~diff[k][DIV_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_W; k++) st_valid[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QUO_W; k++) st_valid[k] <= in_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        st_rem[k]  <= rem_next[k];
        st_div[k]  <= in_d[k];
        st_word[k] <= word_next[k];
        st_side[k] <= in_s[k];
      end
    end
  end

  assign out_valid = st_valid[QUO_W-1];
  assign quotient  = st_word[QUO_W-1];
  assign out_side  = st_side[QUO_W-1];

endmodule
`default_nettype wire

>>> hdl/sgee_sqrt_pipe.sv
// Pipelined integer square root (floor), one root bit per stage, with side data.
`timescale 1ns / 1ps
`default_nettype none
module sgee_sqrt_pipe #(
  parameter int ROOT_W = 31,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] radicand,
  input  logic [SIDE_W-1:0]   side,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int XW   = 2 * ROOT_W;
  localparam int RemW = ROOT_W + 1;
  localparam int TrW  = ROOT_W + 3;

  logic              st_valid [ROOT_W];
  logic [RemW-1:0]   st_rem   [ROOT_W];
  logic [ROOT_W-1:0] st_root  [ROOT_W];
  logic [XW-1:0]     st_x     [ROOT_W];
  logic [SIDE_W-1:0] st_side  [ROOT_W];

  logic              in_v [ROOT_W];
  logic [RemW-1:0]   in_r [ROOT_W];
  logic [ROOT_W-1:0] in_q [ROOT_W];
  logic [XW-1:0]     in_x [ROOT_W];
  logic [SIDE_W-1:0] in_s [ROOT_W];
  logic [TrW-1:0]    trial [ROOT_W];
  logic [TrW:0]      diff  [ROOT_W];
  logic [RemW-1:0]   rem_next  [ROOT_W];
  logic [ROOT_W-1:0] root_next [ROOT_W];

  always_comb begin
    in_v[0] = in_valid;
    in_r[0] = '0;
    in_q[0] = '0;
    in_x[0] = radicand;
    in_s[0] = side;
    for (int k = 1; k < ROOT_W; k++) begin
      in_v[k] = st_valid[k-1];
      in_r[k] = st_rem[k-1];
      in_q[k] = st_root[k-1];
      in_x[k] = st_x[k-1];
      in_s[k] = st_side[k-1];
    end
  end

  // bring in two radicand bits, try root*4+1
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      trial[k]     = {in_r[k], in_x[k][XW-1 -: 2]};
      diff[k]      = {1'b0, trial[k]} - (TrW + 1)'({in_q[k], 2'b01});
      rem_next[k]  = diff[k][TrW] ? trial[k][RemW-1:0] : diff[k][RemW-1:0];
      root_next[k] = {in_q[k][ROOT_W-2:0], ~diff[k][TrW]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) st_valid[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ROOT_W; k++) st_valid[k] <= in_v[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        st_rem[k]  <= rem_next[k];
        st_root[k] <= root_next[k];
        st_x[k]    <= {in_x[k][XW-3:0], 2'b00};
        st_side[k] <= in_s[k];
      end
    end
  end

  assign out_valid = st_valid[ROOT_W-1];
  assign root      = st_root[ROOT_W-1];
  assign out_side  = st_side[ROOT_W-1];

endmodule
`default_nettype wire

>>> hdl/stiffened_gas_eos_eval_unit.sv
// Stiffened-gas EOS evaluator: energy and sound speed from pressure and density.
// Stages from an accepted sample to its result: 3 front stages, 32 energy divider stages,
// 1 energy finish stage, 62 speed divider stages, 31 root stages.
// One item per cycle while no result is held; one bit per stage in both dividers and the root.
// A held result freezes the whole pipeline; bubbles are carried, not squeezed.
// Reset (synchronous, active high) clears all valid bits and loads gamma = 1.4, pinf = einf = 0.
`timescale 1ns / 1ps
`default_nettype none
`include "stiffened_gas_eos_eval_unit_assert.svh"
module stiffened_gas_eos_eval_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  sgee_pkg::sample_t                 sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output sgee_pkg::result_t                 result,
  input  logic                              cfg_write,
  input  logic [1:0]                        cfg_index,
  input  logic [sgee_pkg::DataW-1:0]        cfg_data
);

  localparam int DW    = sgee_pkg::DataW;
  localparam int FW    = sgee_pkg::FracW;
  localparam int GW    = sgee_pkg::GammaW;
  localparam int EQW   = sgee_pkg::EQuoW;
  localparam int SQW   = sgee_pkg::SQuoW;
  localparam int PW    = sgee_pkg::ProdW;
  localparam int SatSh = sgee_pkg::SQuoW - sgee_pkg::FracW;
  localparam int EW    = DW + 2;
  localparam int ESW   = $bits(sgee_pkg::eside_t);
  localparam int SSW   = $bits(sgee_pkg::sside_t);
  localparam int RSW   = $bits(sgee_pkg::rside_t);
  localparam logic [EQW-1:0]       ECap = {1'b1, {(EQW-1){1'b0}}};
  localparam logic signed [EW-1:0] EMax = $signed({3'b000, {(DW-1){1'b1}}});
  localparam logic signed [EW-1:0] EMin = $signed({3'b111, {(DW-1){1'b0}}});

  logic [GW-1:0]        gamma;
  logic signed [DW-1:0] stiff_pressure;
  logic signed [DW-1:0] energy_offset;
  logic                 adv;

  logic                 fr_valid;
  sgee_pkg::front_t     fr;
  sgee_pkg::eside_t     eside_in, eside_out;
  logic [ESW-1:0]       eside_vec;
  logic                 ediv_valid;
  logic [EQW-1:0]       equo;

  logic [EQW-1:0]       qc;
  logic signed [EW-1:0] e_mag, e_signed, e_sum;
  logic signed [DW-1:0] e_final;

  logic                 fin_valid;
  sgee_pkg::sside_t     fin_side, fin_side_next, sside_out;
  logic [PW-1:0]        fin_mag_ns;
  logic [sgee_pkg::SDivW-1:0] fin_mag_rho;
  logic [SSW-1:0]       sside_vec;
  logic                 sdiv_valid;
  logic [SQW-1:0]       squo, rad;

  sgee_pkg::rside_t     rside_in, rside_out;
  logic [RSW-1:0]       rside_vec;
  logic [sgee_pkg::RootW-1:0] root;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gamma          <= sgee_pkg::GammaReset;
      stiff_pressure <= '0;
      energy_offset  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sgee_pkg::CFG_GAMMA:          gamma          <= cfg_data[GW-1:0];
        sgee_pkg::CFG_STIFF_PRESSURE: stiff_pressure <= $signed(cfg_data);
        sgee_pkg::CFG_ENERGY_OFFSET:  energy_offset  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless a finished item is held at the output
  assign adv          = !(result_valid && result_stall);
  assign sample_stall = !adv;

  sgee_front u_front (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .in_valid       (sample_valid),
    .sample         (sample),
    .gamma          (gamma),
    .stiff_pressure (stiff_pressure),
    .out_valid      (fr_valid),
    .front          (fr)
  );

  // energy quotient |num| * 2^16 / |den|
  always_comb begin
    eside_in.neg     = fr.neg;
    eside_in.eerr    = fr.eerr;
    eside_in.esat    = fr.esat;
    eside_in.serr    = fr.serr;
    eside_in.ssat    = fr.ssat;
    eside_in.mag_ns  = fr.mag_ns;
    eside_in.mag_rho = fr.mag_rho;
  end

  sgee_div_pipe #(
    .DIV_W  (sgee_pkg::EDivW),
    .QUO_W  (EQW),
    .SIDE_W (ESW)
  ) u_ediv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fr_valid),
    .divisor   (fr.mag_de),
    .rem_init  (sgee_pkg::EDivW'(fr.mag_ne >> FW)),
    .low_bits  ({fr.mag_ne[FW-1:0], {FW{1'b0}}}),
    .side      (eside_in),
    .out_valid (ediv_valid),
    .quotient  (equo),
    .out_side  (eside_vec)
  );

  assign eside_out = eside_vec;

  // energy finish: cap, sign, subtract einf, clamp; zero on an energy error
  assign qc       = (eside_out.esat || equo > ECap) ? ECap : equo;
  assign e_mag    = $signed({2'b00, qc});
  assign e_signed = eside_out.neg ? -e_mag : e_mag;
  assign e_sum    = e_signed - EW'(energy_offset);

  always_comb begin
    if (eside_out.eerr) begin
      e_final = '0;
    end else if (e_sum > EMax) begin
      e_final = EMax[DW-1:0];
    end else if (e_sum < EMin) begin
      e_final = EMin[DW-1:0];
    end else begin
      e_final = e_sum[DW-1:0];
    end
  end

  always_comb begin
    fin_side_next.energy = e_final;
    fin_side_next.eerr   = eside_out.eerr;
    fin_side_next.serr   = eside_out.serr;
    fin_side_next.ssat   = eside_out.ssat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (adv) begin
      fin_valid <= ediv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_side    <= fin_side_next;
      fin_mag_ns  <= eside_out.mag_ns;
      fin_mag_rho <= eside_out.mag_rho;
    end
  end

  // radicand |g*(p+pinf)| * 2^16 / |rho|
  sgee_div_pipe #(
    .DIV_W  (sgee_pkg::SDivW),
    .QUO_W  (SQW),
    .SIDE_W (SSW)
  ) u_sdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (fin_valid),
    .divisor   (fin_mag_rho),
    .rem_init  (sgee_pkg::SDivW'(fin_mag_ns >> SatSh)),
    .low_bits  ({fin_mag_ns[SatSh-1:0], {FW{1'b0}}}),
    .side      (fin_side),
    .out_valid (sdiv_valid),
    .quotient  (squo),
    .out_side  (sside_vec)
  );

  assign sside_out = sside_vec;

  // saturated radicand roots to the top speed code
  assign rad = sside_out.ssat ? {SQW{1'b1}} : squo;

  always_comb begin
    rside_in.energy = sside_out.energy;
    rside_in.eerr   = sside_out.eerr;
    rside_in.serr   = sside_out.serr;
  end

  sgee_sqrt_pipe #(
    .ROOT_W (sgee_pkg::RootW),
    .SIDE_W (RSW)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sdiv_valid),
    .radicand  (rad),
    .side      (rside_in),
    .out_valid (result_valid),
    .root      (root),
    .out_side  (rside_vec)
  );

  assign rside_out = rside_vec;

  // result item
  always_comb begin
    result.energy       = rside_out.energy;
    result.sound_speed  = root;
    result.energy_error = rside_out.eerr;
    result.speed_error  = rside_out.serr;
  end

  `SGEE_ASSERT_IMP(a_energy_zero_on_err, clk, rst, result_valid && result.energy_error, result.energy == '0)
  `SGEE_ASSERT_IMP(a_speed_zero_on_err, clk, rst, result_valid && (result.speed_error != sgee_pkg::SPEED_OK), result.sound_speed == '0)
  `SGEE_ASSERT_IMP(a_rho_zero_both_err, clk, rst, result_valid && (result.speed_error == sgee_pkg::SPEED_DENSITY_ZERO), result.energy_error)
  `SGEE_ASSERT_NXT(a_finish_holds, clk, rst, !adv && fin_valid, fin_valid && $stable(fin_side))

endmodule
`default_nettype wire

>>> sim/stiffened_gas_eos_eval_unit_test.sv
// Self-checking testbench for the stiffened-gas EOS evaluator.
`timescale 1ns / 1ps
`default_nettype none
module stiffened_gas_eos_eval_unit_test;

  localparam int IdleLimit  = 20000;
  localparam int HoldCycles = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  sgee_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  sgee_pkg::result_t result;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [sgee_pkg::DataW-1:0] cfg_data = '0;

  stiffened_gas_eos_eval_unit i_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // model copy of the configuration
  logic [sgee_pkg::GammaW-1:0] gamma_q = sgee_pkg::GammaReset;
  logic signed [sgee_pkg::DataW-1:0] pinf_q = '0;
  logic signed [sgee_pkg::DataW-1:0] einf_q = '0;

  sgee_pkg::sample_t pending_samples[$];
  sgee_pkg::result_t expected_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_count = 0;
  logic sample_taken = 1'b0;
  int mismatches = 0;
  int results_seen = 0;
  int energy_errors = 0;
  int speed_errors = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  // floor(n * 2^16 / d), clamped to cap
  function automatic logic [63:0] frac_quotient(logic [63:0] n, logic [63:0] d,
                                                logic [63:0] cap);
    logic [63:0] q;
    logic [63:0] r;
    q = n / d;
    r = n % d;
    if (q > cap) return cap;
    for (int i = 0; i < sgee_pkg::FracW; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic sgee_pkg::result_t eos_eval(sgee_pkg::sample_t s);
    sgee_pkg::result_t r;
    longint p, rho, g, pinf, einf, num, den, e, sn;
    logic [63:0] q, c;
    p = longint'(s.pressure);
    rho = longint'(s.density);
    g = longint'({1'b0, gamma_q});
    pinf = longint'(pinf_q);
    einf = longint'(einf_q);
    r = '0;
    r.speed_error = sgee_pkg::SPEED_OK;
    // energy
    num = p * 65536 + g * pinf;
    den = (g - 65536) * rho;
    if (den == 0) begin
      r.energy_error = 1'b1;
    end else begin
      q = frac_quotient(abs64(num), abs64(den), 64'h8000_0000);
      e = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
      e = e - einf;
      if (e > 64'sd2147483647) e = 64'sd2147483647;
      if (e < -64'sd2147483648) e = -64'sd2147483648;
      r.energy = e[31:0];
    end
    // sound speed
    if (rho == 0) begin
      r.speed_error = sgee_pkg::SPEED_DENSITY_ZERO;
    end else begin
      sn = g * (p + pinf);
      if (sn == 0 || ((sn < 0) != (rho < 0))) begin
        r.speed_error = sgee_pkg::SPEED_RADICAND;
      end else begin
        q = frac_quotient(abs64(sn), abs64(rho), 64'd1 << 62);
        c = floor_sqrt(q);
        if (c > 64'h7FFF_FFFF) c = 64'h7FFF_FFFF;
        r.sound_speed = c[30:0];
      end
    end
    return r;
  endfunction

  // driver: offer items at the falling edge, move on once the last edge took one
  always @(negedge clk) begin
    if (!rst) begin
      if (!sample_valid || sample_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_count > 0) begin
        result_stall <= 1'b1;
        hold_count <= hold_count - 1;
      end else if (hold_req && !hold_done) begin
        result_stall <= 1'b1;
        hold_count <= HoldCycles - 1;
        hold_done <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    if (!rst) begin
      sample_taken <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) expected_results.push_back(eos_eval(sample));
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (result_valid && !result_stall) begin
        results_seen++;
        if (result.energy_error) energy_errors++;
        if (result.speed_error != sgee_pkg::SPEED_OK) speed_errors++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          sgee_pkg::result_t ex;
          ex = expected_results.pop_front();
          if (ex !== result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp e=%h c=%h ee=%0d se=%0d got e=%h c=%h ee=%0d se=%0d",
                       ex.energy, ex.sound_speed, ex.energy_error, ex.speed_error,
                       result.energy, result.sound_speed, result.energy_error,
                       result.speed_error);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      timed_out = 1;
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic drain();
    while (pending_samples.size() > 0 || sample_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(sgee_pkg::cfg_index_t idx, logic [sgee_pkg::DataW-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      sgee_pkg::CFG_GAMMA: gamma_q = val[sgee_pkg::GammaW-1:0];
      sgee_pkg::CFG_STIFF_PRESSURE: pinf_q = val;
      default: einf_q = val;
    endcase
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'($urandom_range(65536 * 16));
      2: return -32'($urandom_range(65536 * 16));
      3: return 32'($urandom_range(300));
      4: return 32'h8000_0000 ^ 32'($urandom_range(3));
      default: return {$urandom_range(1) ? 16'h0000 : 16'hFFFF, 16'($urandom)};
    endcase
  endfunction

  task automatic queue_random(int n);
    sgee_pkg::sample_t s;
    for (int i = 0; i < n; i++) begin
      s.pressure = rand_word();
      s.density = ($urandom_range(19) == 0) ? '0 : rand_word();
      pending_samples.push_back(s);
    end
  endtask

  initial begin
    sgee_pkg::sample_t s;
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes under reset settings
    foreach (edges[i]) foreach (edges[j]) begin
      if (pending_samples.size() < 24) begin
        s.pressure = edges[i];
        s.density = edges[j];
        pending_samples.push_back(s);
      end
    end
    drain();
    // gamma of one: energy divisor zero
    write_reg(sgee_pkg::CFG_GAMMA, 32'd65536);
    s.pressure = 32'h0002_0000; s.density = 32'h0001_0000;
    pending_samples.push_back(s);
    queue_random(20);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(sgee_pkg::CFG_GAMMA, sgee_pkg::GammaReset);
                 write_reg(sgee_pkg::CFG_STIFF_PRESSURE, 0);
                 write_reg(sgee_pkg::CFG_ENERGY_OFFSET, 0); end
        1: begin write_reg(sgee_pkg::CFG_GAMMA, 32'hFFFFF);
                 write_reg(sgee_pkg::CFG_STIFF_PRESSURE, 32'h7FFF_FFFF);
                 write_reg(sgee_pkg::CFG_ENERGY_OFFSET, 32'h8000_0000); end
        2: begin write_reg(sgee_pkg::CFG_GAMMA, 32'd0);
                 write_reg(sgee_pkg::CFG_STIFF_PRESSURE, 32'h8000_0000);
                 write_reg(sgee_pkg::CFG_ENERGY_OFFSET, 32'h7FFF_FFFF); end
        3: begin write_reg(sgee_pkg::CFG_GAMMA, 32'd458752);
                 write_reg(sgee_pkg::CFG_STIFF_PRESSURE, 32'h3000_0000);
                 write_reg(sgee_pkg::CFG_ENERGY_OFFSET, $urandom); end
        default: begin write_reg(sgee_pkg::CFG_GAMMA, $urandom);
                 write_reg(sgee_pkg::CFG_STIFF_PRESSURE, rand_word());
                 write_reg(sgee_pkg::CFG_ENERGY_OFFSET, rand_word()); end
      endcase
      send_idle_pct = (ph == 1 || ph == 4) ? 77 : (ph == 3 ? 25 : 0);
      recv_stall_pct = (ph == 2 || ph == 4) ? 77 : (ph == 3 ? 25 : 0);
      if (ph == 0) hold_req = 1'b1;
      queue_random(190);
      drain();
    end

    $display("Covered %0d results (%0d energy errors, %0d speed errors)",
             results_seen, energy_errors, speed_errors);
    $display("over seven register settings, with sender gaps, receiver stalls and a long hold");
    if (mismatches == 0 && !timed_out) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> stiffened_gas_eos_eval_unit.f
+incdir+hdl
hdl/sgee_pkg.sv
hdl/sgee_front.sv
hdl/sgee_div_pipe.sv
hdl/sgee_sqrt_pipe.sv
hdl/stiffened_gas_eos_eval_unit.sv
sim/stiffened_gas_eos_eval_unit_test.sv
